@@ rtl/tbaq_pkg.sv @@
// ----------------------------------------------------------------------------
// tbaq_pkg: shared types and constants for the temperature band alarm qualifier
// Widths, register reset values, register indexes and the per-alarm condition
// bundle passed from the top level to each alarm channel.
// ----------------------------------------------------------------------------
package tbaq_pkg;

    // sample and threshold width (supported range 8..16)
    localparam int TEMP_BITS    = 12;
    localparam int HYST_BITS    = 8;
    localparam int PERSIST_BITS = 8;
    localparam int CNT_BITS     = 8;

    // compare width: threshold +/- hysteresis never wraps
    localparam int BOUND_W      = TEMP_BITS + 2;

    // stream word widths, padded to whole bytes
    localparam int S_TDATA_W    = ((TEMP_BITS + 7) / 8) * 8;
    localparam int M_TDATA_W    = 8;

    // config port
    localparam int CFG_ADDR_W   = 2;
    localparam int CFG_DATA_W   = TEMP_BITS;

    localparam logic [CFG_ADDR_W-1:0] REG_HIGH_THRESHOLD = CFG_ADDR_W'(0);
    localparam logic [CFG_ADDR_W-1:0] REG_LOW_THRESHOLD  = CFG_ADDR_W'(1);
    localparam logic [CFG_ADDR_W-1:0] REG_HYSTERESIS     = CFG_ADDR_W'(2);
    localparam logic [CFG_ADDR_W-1:0] REG_PERSIST_TICKS  = CFG_ADDR_W'(3);

    localparam logic signed [TEMP_BITS-1:0] HIGH_THRESHOLD_RST = TEMP_BITS'(400);
    localparam logic signed [TEMP_BITS-1:0] LOW_THRESHOLD_RST  = TEMP_BITS'(300);
    localparam logic [HYST_BITS-1:0]        HYSTERESIS_RST     = HYST_BITS'(10);
    localparam logic [PERSIST_BITS-1:0]     PERSIST_TICKS_RST  = PERSIST_BITS'(60);

    // result word bit positions
    localparam int HIGH_ALARM_BIT = 0;
    localparam int LOW_ALARM_BIT  = 1;

    // compare results for one alarm on the current sample
    typedef struct packed {
        logic set_hit;    // sample qualifies toward setting the alarm
        logic clear_hit;  // sample qualifies toward clearing the alarm
    } tbaq_cond_t;

endpackage

@@ rtl/tbaq_chan.sv @@
// ----------------------------------------------------------------------------
// tbaq_chan: one alarm flag with its persistence counter
// Picks the set or clear condition by the current flag, counts consecutive
// qualifying words and toggles the flag once the count reaches persistence.
// ----------------------------------------------------------------------------
module tbaq_chan (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 step,
    input  tbaq_pkg::tbaq_cond_t                 cond,
    input  logic [tbaq_pkg::PERSIST_BITS-1:0]    persist_ticks,
    output logic                                 flag,
    output logic                                 flag_next
);
    import tbaq_pkg::*;

    logic                flag_reg;
    logic [CNT_BITS-1:0] count_reg;
    logic [CNT_BITS-1:0] count_next;
    logic [CNT_BITS-1:0] count_inc;
    logic                hit;
    logic                fire;

    // pending condition depends on which way the flag would move
    assign hit       = flag_reg ? cond.clear_hit : cond.set_hit;
    assign count_inc = count_reg + CNT_BITS'(1);
    // zero persistence acts as one; a wrapped count also fires
    assign fire      = (count_inc >= persist_ticks) || (count_inc == '0);

    always_comb begin
        flag_next  = flag_reg;
        count_next = count_reg;
        if (step) begin
            if (hit && fire) begin
                flag_next  = ~flag_reg;
                count_next = '0;
            end else if (hit) begin
                count_next = count_inc;
            end else begin
                count_next = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            flag_reg  <= 1'b0;
            count_reg <= '0;
        end else begin
            flag_reg  <= flag_next;
            count_reg <= count_next;
        end
    end

    assign flag = flag_reg;

endmodule

@@ rtl/temperature_band_alarm_qualifier.sv @@
// ----------------------------------------------------------------------------
// temperature_band_alarm_qualifier: high/low alarms with hysteresis and
// persistence
// One signed temperature word per tick; each alarm sets after persist_ticks
// consecutive words past its threshold and clears after as many words back
// inside the threshold by more than the hysteresis band.
// ----------------------------------------------------------------------------
//  channel   dir  handshake                  payload
//  s_axis    in   s_axis_tvalid/tready       tdata[11:0] temperature (signed)
//  m_axis    out  m_axis_tvalid/tready       tdata[0] high_alarm, [1] low_alarm
//  cfg       in   cfg_valid/cfg_ready        cfg_addr register, cfg_data value
//
//  One word per cycle unless m_axis stalls; the result shows the cycle after accept.
//  The flag/counter update is a single compare-and-increment pass at accept.
//  Reset (aresetn low, synchronous) clears flags, counters and m_axis_tvalid
//  and restores the register defaults.
//  A stalled result holds in the output register; s_axis_tready stays high
//  whenever that register is empty or being drained in the same cycle.
// ----------------------------------------------------------------------------
module temperature_band_alarm_qualifier (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // input stream
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  logic [tbaq_pkg::S_TDATA_W-1:0]       s_axis_tdata,  // [11:0] temperature
    // result stream
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    output logic [tbaq_pkg::M_TDATA_W-1:0]       m_axis_tdata,  // [0] high_alarm,
                                                                // [1] low_alarm
    // register writes
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [tbaq_pkg::CFG_ADDR_W-1:0]      cfg_addr,
    input  logic [tbaq_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import tbaq_pkg::*;

    // ---------------- configuration registers ----------------
    logic signed [TEMP_BITS-1:0] high_threshold_reg;
    logic signed [TEMP_BITS-1:0] low_threshold_reg;
    logic [HYST_BITS-1:0]        hysteresis_reg;
    logic [PERSIST_BITS-1:0]     persist_ticks_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            high_threshold_reg <= HIGH_THRESHOLD_RST;
            low_threshold_reg  <= LOW_THRESHOLD_RST;
            hysteresis_reg     <= HYSTERESIS_RST;
            persist_ticks_reg  <= PERSIST_TICKS_RST;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_addr)
                REG_HIGH_THRESHOLD: high_threshold_reg <= cfg_data[TEMP_BITS-1:0];
                REG_LOW_THRESHOLD:  low_threshold_reg  <= cfg_data[TEMP_BITS-1:0];
                REG_HYSTERESIS:     hysteresis_reg     <= cfg_data[HYST_BITS-1:0];
                REG_PERSIST_TICKS:  persist_ticks_reg  <= cfg_data[PERSIST_BITS-1:0];
                default: ;
            endcase
        end
    end

    // ---------------- handshake ----------------
    logic m_valid_reg;
    logic s_accept;

    // output register takes a new word when empty or drained this cycle
    assign s_axis_tready = ~m_valid_reg | m_axis_tready;
    assign s_accept      = s_axis_tvalid & s_axis_tready;

    // ---------------- compares ----------------
    // everything widened by two bits so threshold +/- hysteresis cannot wrap
    logic signed [TEMP_BITS-1:0] temp;
    logic signed [BOUND_W-1:0]   temp_ext;
    logic signed [BOUND_W-1:0]   high_ext;
    logic signed [BOUND_W-1:0]   low_ext;
    logic signed [BOUND_W-1:0]   hyst_ext;
    logic signed [BOUND_W-1:0]   high_clear_bound;
    logic signed [BOUND_W-1:0]   low_clear_bound;
    tbaq_cond_t                  high_cond;
    tbaq_cond_t                  low_cond;

    assign temp     = s_axis_tdata[TEMP_BITS-1:0];
    assign temp_ext = BOUND_W'(temp);
    assign high_ext = BOUND_W'(high_threshold_reg);
    assign low_ext  = BOUND_W'(low_threshold_reg);
    assign hyst_ext = signed'({{(BOUND_W-HYST_BITS){1'b0}}, hysteresis_reg});

    assign high_clear_bound = high_ext - hyst_ext;
    assign low_clear_bound  = low_ext + hyst_ext;

    assign high_cond.set_hit   = temp_ext >= high_ext;
    assign high_cond.clear_hit = temp_ext <  high_clear_bound;
    assign low_cond.set_hit    = temp_ext <= low_ext;
    assign low_cond.clear_hit  = temp_ext >  low_clear_bound;

    // ---------------- alarm channels ----------------
    logic high_flag, high_flag_next;
    logic low_flag, low_flag_next;

    tbaq_chan u_high (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .step          (s_accept),
        .cond          (high_cond),
        .persist_ticks (persist_ticks_reg),
        .flag          (high_flag),
        .flag_next     (high_flag_next)
    );

    tbaq_chan u_low (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .step          (s_accept),
        .cond          (low_cond),
        .persist_ticks (persist_ticks_reg),
        .flag          (low_flag),
        .flag_next     (low_flag_next)
    );

    // ---------------- result register ----------------
    logic [M_TDATA_W-1:0] m_data_reg;
    logic [M_TDATA_W-1:0] m_data_next;

    always_comb begin
        m_data_next                 = '0;
        m_data_next[HIGH_ALARM_BIT] = high_flag_next;
        m_data_next[LOW_ALARM_BIT]  = low_flag_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_accept) begin
            m_valid_reg <= 1'b1;
        end else if (m_axis_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // payload, no reset needed
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

    // ---------------- assertions ----------------
    // a held result must block new input, or it would be overwritten
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready)
        else $error("input accepted while result stalled");

    // every accepted word yields a result next cycle
    a_result_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> m_axis_tvalid)
        else $error("accepted word produced no result");

    // alarm state only moves on an accepted word
    a_flags_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_accept |=> ($stable(high_flag) && $stable(low_flag)))
        else $error("alarm flag changed without input");

    // result word mirrors the flags it was built from
    a_result_matches: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> (m_axis_tdata[HIGH_ALARM_BIT] == high_flag &&
                      m_axis_tdata[LOW_ALARM_BIT] == low_flag))
        else $error("result word disagrees with alarm flags");

endmodule

@@ sim/temperature_band_alarm_qualifier_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// temperature_band_alarm_qualifier_tb: self-checking bench for the band alarm
// A queue of temperature words feeds a bursty stream driver. Each accepted
// word goes through a local alarm predictor with its own registers, flags and
// persistence counters. The expected flag pair is queued and compared with
// each result word, which is drained under a shifting back-pressure pattern.
// ----------------------------------------------------------------------------
module temperature_band_alarm_qualifier_tb;
    import tbaq_pkg::*;

    localparam int TEMP_MIN    = -(1 << (TEMP_BITS - 1));
    localparam int TEMP_MAX    = (1 << (TEMP_BITS - 1)) - 1;
    localparam int RANDOM_WORDS = 1250;

    // what a queued run of samples aims at
    typedef enum {
        BAND_NOISE,
        BAND_HIGH_SET,
        BAND_HIGH_CLEAR,
        BAND_LOW_SET,
        BAND_LOW_CLEAR
    } band_t;

    // one result word, split into its flags
    typedef struct packed {
        logic high;
        logic low;
    } alarm_t;

    // ------------------------------------------------------------------------
    // DUT ports; every input starts at a known value
    // ------------------------------------------------------------------------
    logic                   aclk          = 1'b0;
    logic                   aresetn       = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [S_TDATA_W-1:0]   s_axis_tdata  = '0;   // [11:0] temperature
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0]   m_axis_tdata;         // [0] high_alarm, [1] low_alarm
    logic                   cfg_valid     = 1'b0;
    logic                   cfg_ready;
    logic [CFG_ADDR_W-1:0]  cfg_addr      = '0;
    logic [CFG_DATA_W-1:0]  cfg_data      = '0;

    temperature_band_alarm_qualifier u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_addr      (cfg_addr),
        .cfg_data      (cfg_data)
    );

    always #2 aclk = ~aclk;

    // ------------------------------------------------------------------------
    // Predictor state: register copies plus flags and persistence counters
    // ------------------------------------------------------------------------
    logic signed [TEMP_BITS-1:0] hi_thr  = HIGH_THRESHOLD_RST;
    logic signed [TEMP_BITS-1:0] lo_thr  = LOW_THRESHOLD_RST;
    logic [HYST_BITS-1:0]        hyst    = HYSTERESIS_RST;
    logic [PERSIST_BITS-1:0]     persist = PERSIST_TICKS_RST;
    bit                          high_on = 1'b0;
    bit                          low_on  = 1'b0;
    logic [CNT_BITS-1:0]         high_run = '0;
    logic [CNT_BITS-1:0]         low_run  = '0;

    logic signed [TEMP_BITS-1:0] sample_q[$];       // words waiting for the driver
    alarm_t                      alarm_expect_q[$]; // flag pairs owed by the DUT

    int queued_count  = 0;
    int checked_count = 0;
    int error_count   = 0;
    int setting_count = 0;
    int high_flips    = 0;
    int low_flips     = 0;

    // ------------------------------------------------------------------------
    // Alarm predictor
    // ------------------------------------------------------------------------
    // One persistence step: a qualifying tick bumps the count and toggles the
    // flag once the count reaches persist (zero persistence toggles at once,
    // an 8-bit wrap also toggles); a breaking tick zeroes the count.
    function automatic logic [CNT_BITS:0] tally(input bit cond, input bit flag,
                                                input logic [CNT_BITS-1:0] run);
        logic [CNT_BITS-1:0] nxt;
        nxt = run + 1'b1;
        if (!cond)
            return {flag, {CNT_BITS{1'b0}}};
        if (nxt >= persist || nxt == '0)
            return {~flag, {CNT_BITS{1'b0}}};
        return {flag, nxt};
    endfunction

    // Full-width int compares, so threshold +/- hysteresis never wraps.
    function automatic alarm_t predict_alarms(input logic signed [TEMP_BITS-1:0] temp);
        int                 t;
        bit                 hc;
        bit                 lc;
        logic [CNT_BITS:0]  nxt;
        alarm_t             res;
        t  = temp;
        hc = high_on ? (t < int'(hi_thr) - int'(hyst)) : (t >= int'(hi_thr));
        lc = low_on  ? (t > int'(lo_thr) + int'(hyst)) : (t <= int'(lo_thr));

        nxt = tally(hc, high_on, high_run);
        if (nxt[CNT_BITS] != high_on)
            high_flips++;
        {high_on, high_run} = nxt;

        nxt = tally(lc, low_on, low_run);
        if (nxt[CNT_BITS] != low_on)
            low_flips++;
        {low_on, low_run} = nxt;

        res.high = high_on;
        res.low  = low_on;
        return res;
    endfunction

    task automatic report_error(input string msg);
        $display("ERROR @%0t result %0d: %s", $realtime, checked_count, msg);
        error_count++;
    endtask

    // ------------------------------------------------------------------------
    // Stream driver: bursts of random length, random gaps, zero-gap stretches
    // ------------------------------------------------------------------------
    int burst_left = 0;
    int gap_left   = 0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_axis_tvalid <= 1'b0;
            burst_left    <= 0;
            gap_left      <= 0;
        end else if (!s_axis_tvalid || s_axis_tready) begin
            // previous word gone (or none up): next word, a gap tick, or idle
            if (gap_left != 0) begin
                s_axis_tvalid <= 1'b0;
                gap_left      <= gap_left - 1;
            end else if (sample_q.size() != 0) begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= S_TDATA_W'($unsigned(sample_q.pop_front()));
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 40);
                    gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result back-pressure: the mode is redrawn at random
    //   free-flowing / random 75% / short periodic dips / long periodic stalls
    // ------------------------------------------------------------------------
    int         stall_mode = 0;
    int         mode_left  = 0;
    logic [4:0] stall_tick = '0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_axis_tready <= 1'b0;
            stall_mode    <= 0;
            mode_left     <= 0;
            stall_tick    <= '0;
        end else begin
            stall_tick <= stall_tick + 1'b1;
            if (mode_left == 0) begin
                stall_mode <= $urandom_range(0, 3);
                mode_left  <= $urandom_range(20, 200);
            end else begin
                mode_left <= mode_left - 1;
            end
            case (stall_mode)
                0: m_axis_tready <= 1'b1;
                1: m_axis_tready <= ($urandom_range(0, 3) != 0);
                2: m_axis_tready <= (stall_tick[2:0] < 3'd5);
                default: m_axis_tready <= (stall_tick < 5'd20);
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: check results first, then predict for the word taken this edge
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin : watch_streams
        alarm_t got;
        alarm_t want;
        if (aresetn) begin
            if (m_axis_tvalid && m_axis_tready) begin
                got.high = m_axis_tdata[HIGH_ALARM_BIT];
                got.low  = m_axis_tdata[LOW_ALARM_BIT];
                if (alarm_expect_q.size() == 0) begin
                    report_error($sformatf("unexpected result word %b%b", got.low, got.high));
                end else begin
                    want = alarm_expect_q.pop_front();
                    if (got.high !== want.high)
                        report_error($sformatf("high_alarm %b, want %b", got.high, want.high));
                    if (got.low !== want.low)
                        report_error($sformatf("low_alarm %b, want %b", got.low, want.low));
                end
                checked_count++;
            end
            if (s_axis_tvalid && s_axis_tready)
                alarm_expect_q.push_back(predict_alarms($signed(s_axis_tdata[TEMP_BITS-1:0])));
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    // Sampled at the falling edge so nothing races the rising-edge updates.
    task automatic wait_idle();
        do
            @(negedge aclk);
        while (sample_q.size() != 0 || s_axis_tvalid || alarm_expect_q.size() != 0);
        repeat (2) @(posedge aclk);
    endtask

    // Only called with the block idle; the predictor takes the value at once.
    task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr,
                             input logic [CFG_DATA_W-1:0] data);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_addr  <= addr;
        cfg_data  <= data;
        do
            @(posedge aclk);
        while (cfg_ready !== 1'b1);
        cfg_valid <= 1'b0;
        case (addr)
            REG_HIGH_THRESHOLD: hi_thr  = $signed(data[TEMP_BITS-1:0]);
            REG_LOW_THRESHOLD:  lo_thr  = $signed(data[TEMP_BITS-1:0]);
            REG_HYSTERESIS:     hyst    = data[HYST_BITS-1:0];
            REG_PERSIST_TICKS:  persist = data[PERSIST_BITS-1:0];
            default: ;
        endcase
    endtask

    // 8-bit registers: junk in the unused upper data bits must be dropped
    function automatic logic [CFG_DATA_W-1:0] narrow_word(input int value);
        return CFG_DATA_W'(($urandom_range(0, 15) << 8) | (value & 8'hFF));
    endfunction

    task automatic apply_setting(input int hi, input int lo, input int hy, input int pe);
        wait_idle();
        write_reg(REG_HIGH_THRESHOLD, CFG_DATA_W'(hi));
        write_reg(REG_LOW_THRESHOLD,  CFG_DATA_W'(lo));
        write_reg(REG_HYSTERESIS,     narrow_word(hy));
        write_reg(REG_PERSIST_TICKS,  narrow_word(pe));
        setting_count++;
    endtask

    task automatic queue_sample(input int t);
        sample_q.push_back(TEMP_BITS'(t));
        queued_count++;
    endtask

    // Uniform in [a, b] clipped to the sample range, half the time hugging
    // one end; an empty region falls back to any value.
    function automatic int pick_between(input int a, input int b);
        int lo_b;
        int hi_b;
        lo_b = (a < TEMP_MIN) ? TEMP_MIN : a;
        hi_b = (b > TEMP_MAX) ? TEMP_MAX : b;
        if (lo_b > hi_b)
            return TEMP_MIN + $urandom_range(0, TEMP_MAX - TEMP_MIN);
        case ($urandom_range(0, 3))
            0: return lo_b + $urandom_range(0, (hi_b - lo_b < 3) ? hi_b - lo_b : 3);
            1: return hi_b - $urandom_range(0, (hi_b - lo_b < 3) ? hi_b - lo_b : 3);
            default: return lo_b + $urandom_range(0, hi_b - lo_b);
        endcase
    endfunction

    function automatic int pick_in_band(input band_t b);
        case (b)
            BAND_HIGH_SET:   return pick_between(hi_thr, TEMP_MAX);
            BAND_HIGH_CLEAR: return pick_between(TEMP_MIN, int'(hi_thr) - int'(hyst) - 1);
            BAND_LOW_SET:    return pick_between(TEMP_MIN, lo_thr);
            BAND_LOW_CLEAR:  return pick_between(int'(lo_thr) + int'(hyst) + 1, TEMP_MAX);
            default:         return pick_between(TEMP_MIN, TEMP_MAX);
        endcase
    endfunction

    function automatic band_t opposite(input band_t b);
        case (b)
            BAND_HIGH_SET:   return BAND_HIGH_CLEAR;
            BAND_HIGH_CLEAR: return BAND_HIGH_SET;
            BAND_LOW_SET:    return BAND_LOW_CLEAR;
            BAND_LOW_CLEAR:  return BAND_LOW_SET;
            default:         return BAND_NOISE;
        endcase
    endfunction

    task automatic queue_run(input band_t b, input int len);
        repeat (len) queue_sample(pick_in_band(b));
    endtask

    // Mostly runs long enough to trip a counter, some cut one short and then
    // broken, some plain noise.
    task automatic queue_episode();
        int    pick;
        int    need;
        band_t b;
        pick = $urandom_range(0, 99);
        need = (persist == 0) ? 1 : int'(persist);
        b    = band_t'($urandom_range(1, 4));
        if (pick < 15) begin
            queue_run(BAND_NOISE, $urandom_range(1, 8));
        end else if (pick < 30) begin
            queue_run(b, (need > 1) ? need - 1 : 1);
            queue_run(opposite(b), 1);
        end else begin
            queue_run(b, need + $urandom_range(0, 2));
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin : main_seq
        int hi;
        int lo;
        int hy;
        int pe;
        int phase_end;
        int target;

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        setting_count = 1;

        // directed, reset registers: range ends and both thresholds' edges
        queue_sample(TEMP_MIN);
        queue_sample(TEMP_MAX);
        queue_sample(0);
        queue_sample(400);
        queue_sample(399);
        queue_sample(300);
        queue_sample(301);

        // zero persistence: flags toggle on the first qualifying word;
        // 390 / 310 sit exactly on the clear bounds and must not clear
        wait_idle();
        write_reg(REG_PERSIST_TICKS, '0);
        setting_count++;
        queue_sample(400);
        queue_sample(390);
        queue_sample(389);
        queue_sample(300);
        queue_sample(310);
        queue_sample(311);

        // persistence lowered below a running count: next hot word trips
        wait_idle();
        write_reg(REG_PERSIST_TICKS, CFG_DATA_W'(60));
        queue_run(BAND_HIGH_SET, 8);
        wait_idle();
        write_reg(REG_PERSIST_TICKS, CFG_DATA_W'(3));
        setting_count++;
        queue_sample(TEMP_MAX);

        target = queued_count + RANDOM_WORDS;

        // extreme settings: widest bands with the longest persistence, then
        // the narrowest with immediate response
        apply_setting(TEMP_MAX, TEMP_MIN, 255, 255);
        queue_run(BAND_HIGH_SET, 256);
        queue_run(BAND_LOW_SET, 40);
        apply_setting(TEMP_MIN, TEMP_MAX, 0, 1);
        repeat (6) queue_episode();

        // random settings; each change waits for a full drain first
        while (queued_count < target) begin
            pe = ($urandom_range(0, 9) == 0) ? 0 :
                 ($urandom_range(0, 3) == 0) ? $urandom_range(7, 20) : $urandom_range(1, 6);
            hi = $urandom_range(0, 3000) - 1500;
            lo = ($urandom_range(0, 6) == 0) ? hi + $urandom_range(0, 200)
                                             : hi - $urandom_range(0, 400);
            hy = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 40);
            if ($urandom_range(0, 3) == 0) begin
                // single register change, counters carry over
                wait_idle();
                case ($urandom_range(0, 3))
                    0: write_reg(REG_HIGH_THRESHOLD, CFG_DATA_W'(hi));
                    1: write_reg(REG_LOW_THRESHOLD,  CFG_DATA_W'(lo));
                    2: write_reg(REG_HYSTERESIS,     narrow_word(hy));
                    default: write_reg(REG_PERSIST_TICKS, narrow_word(pe));
                endcase
                setting_count++;
            end else begin
                apply_setting(hi, lo, hy, pe);
            end
            phase_end = queued_count + $urandom_range(30, 100);
            while (queued_count < phase_end)
                queue_episode();
        end

        wait_idle();
        repeat (8) @(posedge aclk);
        if (alarm_expect_q.size() != 0)
            report_error($sformatf("%0d results never arrived", alarm_expect_q.size()));

        $display("temperature_band_alarm_qualifier_tb: %0d words checked over %0d settings",
                 checked_count, setting_count);
        $display("temperature_band_alarm_qualifier_tb: %0d high / %0d low alarm toggles seen",
                 high_flips, low_flips);
        if (error_count == 0) begin
            $display("temperature_band_alarm_qualifier_tb: done, clean");
        end else begin
            $display("temperature_band_alarm_qualifier_tb: done, errors");
        end
        $finish;
    end

    // watchdog: far beyond the slowest legal run
    initial begin
        #2000000;
        $display("temperature_band_alarm_qualifier_tb: done, errors");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/tbaq_pkg.sv
rtl/tbaq_chan.sv
rtl/temperature_band_alarm_qualifier.sv
sim/temperature_band_alarm_qualifier_tb.sv
